// ===== hdl/rhc_pkg.sv =====
`timescale 1ns / 1ps

package rhc_pkg;

   // Fixed-point formats of components and hue.
   localparam int COMP_FRAC_BITS = 15;
   localparam int HUE_FRAC_BITS  = 6;
   localparam int COMP_W         = 16;

   localparam logic [COMP_W-1:0] ONE_FX    = COMP_W'(1 << COMP_FRAC_BITS);
   localparam logic [COMP_W-1:0] DEG60_FX  = COMP_W'(60 << HUE_FRAC_BITS);
   localparam logic [COMP_W-1:0] DEG360_FX = COMP_W'(360 << HUE_FRAC_BITS);

   // Width of the hue remainder inside one 60 degree sector.
   localparam int FRAC_W = $clog2(60 << HUE_FRAC_BITS);
   // Width of the hue numerator t (below six times delta).
   localparam int T_W    = COMP_W + 3;
   // Product of ls and the sector remainder.
   localparam int LFN_W  = COMP_W + FRAC_W;

   // Divider geometry: quotient bits, divisor width, dividend width.
   localparam int QUO_W = COMP_W;
   localparam int DEN_W = COMP_W;
   localparam int NUM_W = COMP_W + COMP_FRAC_BITS;

   // Operation codes.
   localparam logic OP_TO_HSV = 1'b0;
   localparam logic OP_TO_RGB = 1'b1;

   // Largest component selection.
   typedef enum logic [1:0] {
      MAX_RED   = 2'd0,
      MAX_GREEN = 2'd1,
      MAX_BLUE  = 2'd2
   } max_sel_type;

   // Data that rides beside the divider.
   typedef struct packed {
      logic              op;
      logic              err;
      logic              undef;
      logic              grey;
      logic [COMP_W-1:0] v;
      logic [COMP_W-1:0] ls;
      logic [2:0]        sector;
   } side_type;

endpackage

// ===== hdl/rhc_prep.sv =====
`timescale 1ns / 1ps

module rhc_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic                          in_operation,
   input  logic [rhc_pkg::COMP_W-1:0]    in_a,
   input  logic [rhc_pkg::COMP_W-1:0]    in_b,
   input  logic [rhc_pkg::COMP_W-1:0]    in_c,
   input  logic                          in_hue_undefined,
   output logic                          out_valid,
   output rhc_pkg::side_type             out_side,
   output logic [rhc_pkg::NUM_W-1:0]     out_num0,
   output logic [rhc_pkg::DEN_W-1:0]     out_den0,
   output logic [rhc_pkg::NUM_W-1:0]     out_num1,
   output logic [rhc_pkg::DEN_W-1:0]     out_den1
);
   import rhc_pkg::*;

   // Stage 1 registers.
   logic                p1_valid_ff;
   logic                p1_op_ff, p1_op_in;
   logic                p1_err_ff, p1_err_in;
   logic [COMP_W-1:0]   p1_mx_ff, p1_mx_in;
   logic [COMP_W-1:0]   p1_mn_ff, p1_mn_in;
   max_sel_type         p1_sel_ff, p1_sel_in;
   logic [COMP_W-1:0]   p1_pa_ff, p1_pa_in;
   logic [COMP_W-1:0]   p1_pb_ff, p1_pb_in;
   logic [COMP_W-1:0]   p1_v_ff, p1_v_in;
   logic [COMP_W-1:0]   p1_ls_ff, p1_ls_in;
   logic [2:0]          p1_sector_ff, p1_sector_in;
   logic [FRAC_W-1:0]   p1_frac_ff, p1_frac_in;
   logic                p1_grey_ff, p1_grey_in;

   // Stage 2 registers.
   logic                p2_valid_ff;
   side_type            p2_side_ff, p2_side_in;
   logic [COMP_W-1:0]   p2_delta_ff, p2_delta_in;
   logic [T_W-1:0]      p2_t_ff, p2_t_in;
   logic [LFN_W-1:0]    p2_lfn_ff, p2_lfn_in;

   // Stage 3 registers.
   logic                p3_valid_ff;
   side_type            p3_side_ff;
   logic [NUM_W-1:0]    p3_num0_ff, p3_num0_in;
   logic [DEN_W-1:0]    p3_den0_ff, p3_den0_in;
   logic [NUM_W-1:0]    p3_num1_ff, p3_num1_in;
   logic [DEN_W-1:0]    p3_den1_ff, p3_den1_in;

   logic [2*COMP_W-1:0] vs_prod;
   logic [COMP_W-1:0]   hue_fold;
   logic [COMP_W-1:0]   sector_base;

   // Stage 1: range checks, largest and smallest component, hue sector, ls.
   always_comb begin
      p1_op_in = in_operation;
      p1_mx_in = in_a;
      p1_mn_in = in_a;
      p1_sel_in = MAX_RED;
      p1_pa_in = in_b;
      p1_pb_in = in_c;
      if (in_b > p1_mx_in) begin
         p1_mx_in = in_b;
         p1_sel_in = MAX_GREEN;
         p1_pa_in = in_c;
         p1_pb_in = in_a;
      end
      if (in_c > p1_mx_in) begin
         p1_mx_in = in_c;
         p1_sel_in = MAX_BLUE;
         p1_pa_in = in_a;
         p1_pb_in = in_b;
      end
      if (in_b < p1_mn_in) begin
         p1_mn_in = in_b;
      end
      if (in_c < p1_mn_in) begin
         p1_mn_in = in_c;
      end

      // Reverse direction: fold 360 degrees to 0 and find the sector.
      hue_fold = (in_a == DEG360_FX) ? '0 : in_a;
      priority if (hue_fold >= COMP_W'(5 * DEG60_FX)) begin
         p1_sector_in = 3'd5;
         sector_base = COMP_W'(5 * DEG60_FX);
      end else if (hue_fold >= COMP_W'(4 * DEG60_FX)) begin
         p1_sector_in = 3'd4;
         sector_base = COMP_W'(4 * DEG60_FX);
      end else if (hue_fold >= COMP_W'(3 * DEG60_FX)) begin
         p1_sector_in = 3'd3;
         sector_base = COMP_W'(3 * DEG60_FX);
      end else if (hue_fold >= COMP_W'(2 * DEG60_FX)) begin
         p1_sector_in = 3'd2;
         sector_base = COMP_W'(2 * DEG60_FX);
      end else if (hue_fold >= DEG60_FX) begin
         p1_sector_in = 3'd1;
         sector_base = DEG60_FX;
      end else begin
         p1_sector_in = 3'd0;
         sector_base = '0;
      end
      p1_frac_in = FRAC_W'(hue_fold - sector_base);

      vs_prod = (2*COMP_W)'(in_b) * (2*COMP_W)'(in_c);
      p1_ls_in = COMP_W'(vs_prod >> COMP_FRAC_BITS);
      p1_v_in = in_b;
      p1_grey_in = in_hue_undefined;

      if (in_operation == OP_TO_HSV) begin
         p1_err_in = (in_a > ONE_FX) || (in_b > ONE_FX) || (in_c > ONE_FX);
      end else begin
         p1_err_in = (in_b > ONE_FX) || (in_c > ONE_FX)
                  || (in_hue_undefined && (in_c != '0))
                  || (!in_hue_undefined && (in_a > DEG360_FX));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_op_ff <= p1_op_in;
         p1_err_ff <= p1_err_in;
         p1_mx_ff <= p1_mx_in;
         p1_mn_ff <= p1_mn_in;
         p1_sel_ff <= p1_sel_in;
         p1_pa_ff <= p1_pa_in;
         p1_pb_ff <= p1_pb_in;
         p1_v_ff <= p1_v_in;
         p1_ls_ff <= p1_ls_in;
         p1_sector_ff <= p1_sector_in;
         p1_frac_ff <= p1_frac_in;
         p1_grey_ff <= p1_grey_in;
      end
   end

   // Stage 2: delta and hue numerator, or the ls times remainder product.
   logic [T_W-1:0] plus_d;
   logic [T_W-1:0] diff_pos;
   logic [T_W-1:0] diff_neg;
   logic [T_W-1:0] six_d;

   always_comb begin
      p2_delta_in = p1_mx_ff - p1_mn_ff;
      unique case (p1_sel_ff)
         MAX_RED:   plus_d = '0;
         MAX_GREEN: plus_d = T_W'(p2_delta_in) << 1;
         MAX_BLUE:  plus_d = T_W'(p2_delta_in) << 2;
         default:   plus_d = '0;
      endcase
      diff_pos = T_W'(p1_pa_ff) - T_W'(p1_pb_ff);
      diff_neg = T_W'(p1_pb_ff) - T_W'(p1_pa_ff);
      six_d = (T_W'(p2_delta_in) << 2) + (T_W'(p2_delta_in) << 1);
      priority if (p1_pa_ff >= p1_pb_ff) begin
         p2_t_in = plus_d + diff_pos;
      end else if (plus_d >= diff_neg) begin
         p2_t_in = plus_d - diff_neg;
      end else begin
         p2_t_in = six_d - diff_neg;
      end

      p2_lfn_in = LFN_W'(p1_ls_ff) * LFN_W'(p1_frac_ff);

      p2_side_in.op = p1_op_ff;
      p2_side_in.err = p1_err_ff;
      p2_side_in.undef = (p1_op_ff == OP_TO_HSV) && (p2_delta_in == '0);
      p2_side_in.grey = p1_grey_ff;
      p2_side_in.v = (p1_op_ff == OP_TO_HSV) ? p1_mx_ff : p1_v_ff;
      p2_side_in.ls = p1_ls_ff;
      p2_side_in.sector = p1_sector_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_side_ff <= p2_side_in;
         p2_delta_ff <= p2_delta_in;
         p2_t_ff <= p2_t_in;
         p2_lfn_ff <= p2_lfn_in;
      end
   end

   // Stage 3: dividend and divisor of both divider lanes.
   always_comb begin
      if (p2_side_ff.op == OP_TO_HSV) begin
         p3_num0_in = NUM_W'(p2_delta_ff) << COMP_FRAC_BITS;
         p3_den0_in = p2_side_ff.v;
         p3_num1_in = NUM_W'(p2_t_ff) * NUM_W'(DEG60_FX);
         p3_den1_in = p2_delta_ff;
      end else begin
         p3_num0_in = NUM_W'(p2_lfn_ff);
         p3_den0_in = DEG60_FX;
         p3_num1_in = '0;
         p3_den1_in = DEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_side_ff <= p2_side_ff;
         p3_num0_ff <= p3_num0_in;
         p3_den0_ff <= p3_den0_in;
         p3_num1_ff <= p3_num1_in;
         p3_den1_ff <= p3_den1_in;
      end
   end

   assign out_valid = p3_valid_ff;
   assign out_side = p3_side_ff;
   assign out_num0 = p3_num0_ff;
   assign out_den0 = p3_den0_ff;
   assign out_num1 = p3_num1_ff;
   assign out_den1 = p3_den1_ff;

endmodule

// ===== hdl/rhc_div.sv =====
`timescale 1ns / 1ps

module rhc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rhc_pkg::side_type             in_side,
   input  logic [rhc_pkg::NUM_W-1:0]     in_num0,
   input  logic [rhc_pkg::DEN_W-1:0]     in_den0,
   input  logic [rhc_pkg::NUM_W-1:0]     in_num1,
   input  logic [rhc_pkg::DEN_W-1:0]     in_den1,
   output logic                          out_valid,
   output rhc_pkg::side_type             out_side,
   output logic [rhc_pkg::QUO_W-1:0]     out_quo0,
   output logic [rhc_pkg::QUO_W-1:0]     out_quo1
);
   import rhc_pkg::*;

   localparam int LANES = 2;

   // One quotient bit per stage, most significant first, two lanes side by side.
   logic [QUO_W-1:0] valid_ff;
   side_type         side_ff  [QUO_W];
   side_type         side_src [QUO_W];
   logic [NUM_W-1:0] rem_ff   [QUO_W][LANES];
   logic [NUM_W-1:0] rem_src  [QUO_W][LANES];
   logic [NUM_W-1:0] rem_in   [QUO_W][LANES];
   logic [DEN_W-1:0] den_ff   [QUO_W][LANES];
   logic [DEN_W-1:0] den_src  [QUO_W][LANES];
   logic [QUO_W-1:0] quo_ff   [QUO_W][LANES];
   logic [QUO_W-1:0] quo_src  [QUO_W][LANES];
   logic [QUO_W-1:0] quo_in   [QUO_W][LANES];
   logic             valid_src[QUO_W];

   genvar k, l;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         localparam int SH = QUO_W - 1 - k;

         // Stage input comes from the ports or from the previous stage.
         if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign side_src[k] = in_side;
            assign rem_src[k][0] = in_num0;
            assign den_src[k][0] = in_den0;
            assign quo_src[k][0] = '0;
            assign rem_src[k][1] = in_num1;
            assign den_src[k][1] = in_den1;
            assign quo_src[k][1] = '0;
         end else begin : g_next
            assign valid_src[k] = valid_ff[k-1];
            assign side_src[k] = side_ff[k-1];
            for (l = 0; l < LANES; l++) begin : g_link
               assign rem_src[k][l] = rem_ff[k-1][l];
               assign den_src[k][l] = den_ff[k-1][l];
               assign quo_src[k][l] = quo_ff[k-1][l];
            end
         end

         // Trial subtraction of the shifted divisor.
         for (l = 0; l < LANES; l++) begin : g_lane
            logic [NUM_W:0] trial;

            always_comb begin
               trial = {1'b0, rem_src[k][l]} - {1'b0, NUM_W'(den_src[k][l]) << SH};
               quo_in[k][l] = quo_src[k][l];
               quo_in[k][l][SH] = ~trial[NUM_W];
               rem_in[k][l] = trial[NUM_W] ? rem_src[k][l] : trial[NUM_W-1:0];
            end

            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k][l] <= rem_in[k][l];
                  den_ff[k][l] <= den_src[k][l];
                  quo_ff[k][l] <= quo_in[k][l];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= valid_src[k];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[k] <= side_src[k];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[QUO_W-1];
   assign out_side = side_ff[QUO_W-1];
   assign out_quo0 = quo_ff[QUO_W-1][0];
   assign out_quo1 = quo_ff[QUO_W-1][1];

endmodule

// ===== hdl/rhc_post.sv =====
`timescale 1ns / 1ps

module rhc_post (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  rhc_pkg::side_type             in_side,
   input  logic [rhc_pkg::QUO_W-1:0]     in_quo0,
   input  logic [rhc_pkg::QUO_W-1:0]     in_quo1,
   output logic                          out_valid,
   output logic [rhc_pkg::COMP_W-1:0]    out_a,
   output logic [rhc_pkg::COMP_W-1:0]    out_b,
   output logic [rhc_pkg::COMP_W-1:0]    out_c,
   output logic                          out_hue_undefined,
   output logic                          out_status
);
   import rhc_pkg::*;

   logic              valid_ff;
   logic [COMP_W-1:0] a_ff, a_in;
   logic [COMP_W-1:0] b_ff, b_in;
   logic [COMP_W-1:0] c_ff, c_in;
   logic              undef_ff, undef_in;
   logic              status_ff, status_in;

   logic [COMP_W-1:0] lo;
   logic [COMP_W-1:0] rise;
   logic [COMP_W-1:0] fall;

   // Assemble the result from the quotients and the side data.
   always_comb begin
      lo = in_side.v - in_side.ls;
      rise = lo + in_quo0;
      fall = in_side.v - in_quo0;
      a_in = '0;
      b_in = '0;
      c_in = '0;
      undef_in = 1'b0;
      status_in = 1'b0;
      priority if (in_side.err) begin
         status_in = 1'b1;
      end else if (in_side.op == OP_TO_HSV) begin
         b_in = in_side.v;
         if (in_side.undef) begin
            undef_in = 1'b1;
         end else begin
            a_in = in_quo1;
            c_in = in_quo0;
         end
      end else if (in_side.grey) begin
         a_in = in_side.v;
         b_in = in_side.v;
         c_in = in_side.v;
      end else begin
         unique case (in_side.sector)
            3'd0: begin
               a_in = in_side.v; b_in = rise; c_in = lo;
            end
            3'd1: begin
               a_in = fall; b_in = in_side.v; c_in = lo;
            end
            3'd2: begin
               a_in = lo; b_in = in_side.v; c_in = rise;
            end
            3'd3: begin
               a_in = lo; b_in = fall; c_in = in_side.v;
            end
            3'd4: begin
               a_in = rise; b_in = lo; c_in = in_side.v;
            end
            default: begin
               a_in = in_side.v; b_in = lo; c_in = fall;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         undef_ff <= undef_in;
         status_ff <= status_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_a = a_ff;
   assign out_b = b_ff;
   assign out_c = c_ff;
   assign out_hue_undefined = undef_ff;
   assign out_status = status_ff;

endmodule

// ===== hdl/rgb_hsv_color_convert_top.sv =====
`timescale 1ns / 1ps
// RGB to hue/value/saturation converter and back, one request per clock.
// Components are unsigned Q1.15 and hue is unsigned Q10.6 degrees. A request
// passes three preparation stages, a 16-stage pipelined divider that yields
// one quotient bit per stage, and the output register on its way to the
// response. A new request is taken in every cycle while the response side is
// not stalled; a stall on the response side holds the whole pipeline.
// Out-of-range inputs give status 1 with all other fields 0.

module rgb_hsv_color_convert_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [rhc_pkg::COMP_W-1:0]    req_in_a,
   input  logic [rhc_pkg::COMP_W-1:0]    req_in_b,
   input  logic [rhc_pkg::COMP_W-1:0]    req_in_c,
   input  logic                          req_in_hue_undefined,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rhc_pkg::COMP_W-1:0]    rsp_out_a,
   output logic [rhc_pkg::COMP_W-1:0]    rsp_out_b,
   output logic [rhc_pkg::COMP_W-1:0]    rsp_out_c,
   output logic                          rsp_out_hue_undefined,
   output logic                          rsp_status
);
   import rhc_pkg::*;

   logic             en;
   logic             prep_valid;
   side_type         prep_side;
   logic [NUM_W-1:0] prep_num0;
   logic [DEN_W-1:0] prep_den0;
   logic [NUM_W-1:0] prep_num1;
   logic [DEN_W-1:0] prep_den1;
   logic             div_valid;
   side_type         div_side;
   logic [QUO_W-1:0] div_quo0;
   logic [QUO_W-1:0] div_quo1;

   // The pipeline moves whenever the response register is free or drained.
   assign en = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~en;

   rhc_prep u_prep (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (req_valid),
      .in_operation     (req_operation),
      .in_a             (req_in_a),
      .in_b             (req_in_b),
      .in_c             (req_in_c),
      .in_hue_undefined (req_in_hue_undefined),
      .out_valid        (prep_valid),
      .out_side         (prep_side),
      .out_num0         (prep_num0),
      .out_den0         (prep_den0),
      .out_num1         (prep_num1),
      .out_den1         (prep_den1)
   );

   rhc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .in_side   (prep_side),
      .in_num0   (prep_num0),
      .in_den0   (prep_den0),
      .in_num1   (prep_num1),
      .in_den1   (prep_den1),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_quo0  (div_quo0),
      .out_quo1  (div_quo1)
   );

   rhc_post u_post (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .in_valid          (div_valid),
      .in_side           (div_side),
      .in_quo0           (div_quo0),
      .in_quo1           (div_quo1),
      .out_valid         (rsp_valid),
      .out_a             (rsp_out_a),
      .out_b             (rsp_out_b),
      .out_c             (rsp_out_c),
      .out_hue_undefined (rsp_out_hue_undefined),
      .out_status        (rsp_status)
   );

   // An error response carries nothing but the status.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_out_a == '0 && rsp_out_b == '0
         && rsp_out_c == '0 && !rsp_out_hue_undefined))
      else $error("error response with nonzero fields");

   // An undefined hue comes with zero hue and zero saturation.
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_hue_undefined) |-> (rsp_out_a == '0
         && rsp_out_c == '0 && !rsp_status))
      else $error("undefined hue with nonzero hue or saturation");

   // Every valid component or value stays within 1.0.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_a <= ONE_FX && rsp_out_b <= ONE_FX
         && rsp_out_c <= ONE_FX))
      else $error("response field above 1.0");

endmodule
